FILE: hw/rtl/odometer_pulse_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the odometer pulse counter
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef ODOMETER_PULSE_COUNTER_TOP_DEFINES_SVH
`define ODOMETER_PULSE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication
`define OPC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometer pulse counter: same-cycle check failed");

// next-cycle implication
`define OPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometer pulse counter: next-cycle check failed");

`endif

FILE: hw/rtl/opc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_pkg
// Shared widths, codes, word types and address mapping for the odometer.
// ----------------------------------------------------------------------------
package opc_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int PPM_W      = 16;
    localparam int TRIP_W     = 14;
    localparam int DIG_W      = 7;
    localparam int DEC_W      = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // write slots per item, in emission order
    localparam int NSLOT  = 5;
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_TRIP_LO = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_TRIP_HI = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_DLOW    = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_DMID    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DHIGH   = 3'd4;

    // descriptor queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // counter limits
    localparam logic [TRIP_W-1:0] TRIP_MAX    = 14'd9999;
    localparam logic [DIG_W:0]    DIGIT_LIMIT = 8'd100;
    localparam logic [DEC_W-1:0]  DECADE_WRAP = 4'd10;
    localparam logic [DEC_W-1:0]  DECADE_HALF = 4'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PPM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUEL = 1'b1;
    localparam logic [PPM_W-1:0]     PPM_RESET = 16'd1000;

    // nonvolatile byte addresses
    localparam logic [ADDR_W-1:0] ADDR_NONE      = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_DIST_LOW  = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_DIST_MID  = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_DIST_HIGH = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_TRIP_LOW  = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_TRIP_HIGH = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_GAS_LOW   = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_GAS_HIGH  = 4'd10;

    typedef enum logic [OP_W-1:0] {
        OP_PULSE = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } opcode_t;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TRIP_W-1:0] load_trip;
        logic [DIG_W-1:0]  load_low;
        logic [DIG_W-1:0]  load_mid;
        logic [DIG_W-1:0]  load_high;
    } item_t;

    // result word
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic              last_result;
        logic [TRIP_W-1:0] trip_value;
        logic [DIG_W-1:0]  dist_low;
        logic [DIG_W-1:0]  dist_mid;
        logic [DIG_W-1:0]  dist_high;
    } result_t;

    // classified item: which writes to issue, their data and the counters
    typedef struct packed {
        logic [NSLOT-1:0]  mask;
        logic              gas;
        logic [DATA_W-1:0] trip_lo;
        logic [DATA_W-1:0] trip_hi;
        logic [DIG_W-1:0]  wr_low;
        logic [DIG_W-1:0]  wr_mid;
        logic [DIG_W-1:0]  wr_high;
        logic [TRIP_W-1:0] trip_value;
        logic [DIG_W-1:0]  dist_low;
        logic [DIG_W-1:0]  dist_mid;
        logic [DIG_W-1:0]  dist_high;
    } desc_t;

    // byte address of a write slot
    function automatic logic [ADDR_W-1:0] slot_address(input logic [SLOT_W-1:0] slot,
                                                       input logic gas);
        logic [ADDR_W-1:0] a;
        a = ADDR_NONE;
        case (slot)
            SLOT_TRIP_LO: a = gas ? ADDR_GAS_LOW : ADDR_TRIP_LOW;
            SLOT_TRIP_HI: a = gas ? ADDR_GAS_HIGH : ADDR_TRIP_HIGH;
            SLOT_DLOW:    a = ADDR_DIST_LOW;
            SLOT_DMID:    a = ADDR_DIST_MID;
            SLOT_DHIGH:   a = ADDR_DIST_HIGH;
            default:      a = ADDR_NONE;
        endcase
        return a;
    endfunction

endpackage

FILE: hw/rtl/opc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_front
// Holds the counters, flags and configuration; turns each accepted word
// into a write descriptor in the same cycle.
// ----------------------------------------------------------------------------
module opc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [opc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [opc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              accept,
    input  opc_pkg::item_t                    item,
    output opc_pkg::desc_t                    desc
);
    import opc_pkg::*;

    logic [PPM_W-1:0]  ppm_reg;
    logic              fuel_reg;
    logic [PPM_W-1:0]  prescale_reg, prescale_next;
    logic [TRIP_W-1:0] trip_reg, trip_next;
    logic [DEC_W-1:0]  decade_reg, decade_next;
    logic [DIG_W-1:0]  low_reg, low_next;
    logic [DIG_W-1:0]  mid_reg, mid_next;
    logic [DIG_W-1:0]  high_reg, high_next;
    logic              done_reg, done_next;
    logic              half_reg, half_next;
    logic              low_dirty_reg, low_dirty_next;
    logic              mid_dirty_reg, mid_dirty_next;
    logic              high_dirty_reg, high_dirty_next;
    logic              hstored_reg, hstored_next;

    logic [PPM_W-1:0]  pre_inc;
    logic [TRIP_W:0]   trip_sum;
    logic [TRIP_W-1:0] trip_wrap;
    logic [DEC_W-1:0]  dec_inc;
    logic [DIG_W:0]    low_inc, mid_inc, high_inc;
    logic              carry, mid_eff, high_eff;

    // increments shared by pulse and store check
    assign pre_inc   = prescale_reg + 1'b1;
    assign trip_sum  = {1'b0, trip_reg} + 1'b1;
    assign trip_wrap = (trip_sum > {1'b0, TRIP_MAX}) ? '0 : trip_sum[TRIP_W-1:0];
    assign dec_inc   = decade_reg + 1'b1;
    assign low_inc   = {1'b0, low_reg} + 1'b1;
    assign mid_inc   = {1'b0, mid_reg} + 1'b1;
    assign high_inc  = {1'b0, high_reg} + 1'b1;

    // classify the word and work out the next state
    always_comb
    begin
        prescale_next   = prescale_reg;
        trip_next       = trip_reg;
        decade_next     = decade_reg;
        low_next        = low_reg;
        mid_next        = mid_reg;
        high_next       = high_reg;
        done_next       = done_reg;
        half_next       = half_reg;
        low_dirty_next  = low_dirty_reg;
        mid_dirty_next  = mid_dirty_reg;
        high_dirty_next = high_dirty_reg;
        hstored_next    = hstored_reg;
        desc.mask       = '0;
        desc.trip_lo    = '0;
        desc.trip_hi    = '0;
        desc.wr_low     = '0;
        desc.wr_mid     = '0;
        desc.wr_high    = '0;
        carry           = 1'b0;
        mid_eff         = mid_dirty_reg;
        high_eff        = high_dirty_reg;

        case (opcode_t'(item.opcode))
            OP_PULSE:
            begin
                if (pre_inc < ppm_reg)
                begin
                    prescale_next = pre_inc;
                end
                else
                begin
                    prescale_next = '0;
                    trip_next     = trip_wrap;
                    done_next     = 1'b1;
                    if (dec_inc < DECADE_WRAP)
                    begin
                        decade_next = dec_inc;
                    end
                    else
                    begin
                        decade_next    = '0;
                        low_dirty_next = 1'b1;
                        if (low_inc >= DIGIT_LIMIT)
                        begin
                            low_next       = '0;
                            mid_dirty_next = 1'b1;
                            if (mid_inc >= DIGIT_LIMIT)
                            begin
                                mid_next        = '0;
                                high_dirty_next = 1'b1;
                                high_next       = (high_inc >= DIGIT_LIMIT) ? '0
                                                                            : high_inc[DIG_W-1:0];
                            end
                            else
                            begin
                                mid_next = mid_inc[DIG_W-1:0];
                            end
                        end
                        else
                        begin
                            low_next = low_inc[DIG_W-1:0];
                        end
                    end
                end
            end

            OP_STORE:
            begin
                // half-way through a 100 m step: pre-store trip + 1
                if ((prescale_reg == (ppm_reg >> 1)) && !half_reg)
                begin
                    desc.mask[SLOT_TRIP_LO] = 1'b1;
                    desc.trip_lo            = trip_wrap[DATA_W-1:0];
                    desc.mask[SLOT_TRIP_HI] = (trip_wrap[DATA_W-1:0] == '0);
                    desc.trip_hi            = {{(2*DATA_W-TRIP_W){1'b0}},
                                               trip_wrap[TRIP_W-1:DATA_W]};
                    half_next               = 1'b1;
                end
                if (done_reg)
                begin
                    done_next = 1'b0;
                    half_next = 1'b0;
                end

                // half-way through a kilometre: pre-store next low digit
                if ((decade_reg == DECADE_HALF) && !hstored_reg)
                begin
                    desc.mask[SLOT_DLOW] = 1'b1;
                    if (low_inc >= DIGIT_LIMIT)
                    begin
                        desc.wr_low = '0;
                        mid_eff     = 1'b1;
                        carry       = 1'b1;
                    end
                    else
                    begin
                        desc.wr_low = low_inc[DIG_W-1:0];
                    end
                    hstored_next = 1'b1;
                end
                if (low_dirty_reg)
                begin
                    low_dirty_next = 1'b0;
                    hstored_next   = 1'b0;
                end

                // mid digit rewrite, carry may ripple on
                if (mid_eff)
                begin
                    desc.mask[SLOT_DMID] = 1'b1;
                    if (carry)
                    begin
                        if (mid_inc >= DIGIT_LIMIT)
                        begin
                            desc.wr_mid = '0;
                            high_eff    = 1'b1;
                        end
                        else
                        begin
                            desc.wr_mid = mid_inc[DIG_W-1:0];
                            carry       = 1'b0;
                        end
                    end
                    else
                    begin
                        desc.wr_mid = mid_reg;
                    end
                    mid_dirty_next = 1'b0;
                end

                // high digit rewrite
                if (high_eff)
                begin
                    desc.mask[SLOT_DHIGH] = 1'b1;
                    if (carry)
                    begin
                        desc.wr_high = (high_inc >= DIGIT_LIMIT) ? '0 : high_inc[DIG_W-1:0];
                    end
                    else
                    begin
                        desc.wr_high = high_reg;
                    end
                    high_dirty_next = 1'b0;
                end
            end

            OP_CLEAR:
            begin
                trip_next               = '0;
                prescale_next           = '0;
                desc.mask[SLOT_TRIP_LO] = 1'b1;
                desc.mask[SLOT_TRIP_HI] = 1'b1;
            end

            OP_LOAD:
            begin
                trip_next       = item.load_trip;
                low_next        = item.load_low;
                mid_next        = item.load_mid;
                high_next       = item.load_high;
                prescale_next   = '0;
                decade_next     = '0;
                done_next       = 1'b0;
                half_next       = 1'b0;
                low_dirty_next  = 1'b0;
                mid_dirty_next  = 1'b0;
                high_dirty_next = 1'b0;
                hstored_next    = 1'b0;
            end

            default:
            begin
                prescale_next = prescale_reg;
            end
        endcase

        // counters after the word
        desc.gas        = fuel_reg;
        desc.trip_value = trip_next;
        desc.dist_low   = low_next;
        desc.dist_mid   = mid_next;
        desc.dist_high  = high_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppm_reg  <= PPM_RESET;
            fuel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PPM)
            begin
                ppm_reg <= cfg_data[PPM_W-1:0];
            end
            if (cfg_index == CFG_FUEL)
            begin
                fuel_reg <= cfg_data[0];
            end
        end
    end

    // counter and flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg   <= '0;
            trip_reg       <= '0;
            decade_reg     <= '0;
            low_reg        <= '0;
            mid_reg        <= '0;
            high_reg       <= '0;
            done_reg       <= 1'b0;
            half_reg       <= 1'b0;
            low_dirty_reg  <= 1'b0;
            mid_dirty_reg  <= 1'b0;
            high_dirty_reg <= 1'b0;
            hstored_reg    <= 1'b0;
        end
        else if (accept)
        begin
            prescale_reg   <= prescale_next;
            trip_reg       <= trip_next;
            decade_reg     <= decade_next;
            low_reg        <= low_next;
            mid_reg        <= mid_next;
            high_reg       <= high_next;
            done_reg       <= done_next;
            half_reg       <= half_next;
            low_dirty_reg  <= low_dirty_next;
            mid_dirty_reg  <= mid_dirty_next;
            high_dirty_reg <= high_dirty_next;
            hstored_reg    <= hstored_next;
        end
    end

endmodule

FILE: hw/rtl/opc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_queue
// Short register queue of write descriptors between front and back.
// ----------------------------------------------------------------------------
`include "odometer_pulse_counter_top_defines.svh"

module opc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  opc_pkg::desc_t wr_data,
    input  logic           rd_en,
    output opc_pkg::desc_t rd_data,
    output logic           valid,
    output logic           full
);
    import opc_pkg::*;

    desc_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign rd_data = entry_reg[rd_ptr_reg];
    assign valid   = (count_reg != '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `OPC_ASSERT_IMP(a_q_no_overflow, wr_en && !rd_en, count_reg != QCNT_W'(QDEPTH))
    `OPC_ASSERT_IMP(a_q_no_underflow, rd_en, count_reg != '0)
    `OPC_ASSERT_NEXT(a_q_count_up, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: hw/rtl/opc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_back
// Expands the head descriptor into result words in an output register,
// one per cycle while the held result is popped or the register is empty.
// ----------------------------------------------------------------------------
`include "odometer_pulse_counter_top_defines.svh"

module opc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  opc_pkg::desc_t  head,
    output logic            q_pop,
    output opc_pkg::result_t result,
    output logic            empty,
    input  logic            pop
);
    import opc_pkg::*;

    logic [NSLOT-1:0]  done_mask_reg, done_mask_next;
    logic              out_valid_reg;
    result_t           out_reg;

    logic [NSLOT-1:0]  remaining;
    logic [NSLOT-1:0]  sel;
    logic [SLOT_W-1:0] idx;
    logic              found;
    logic              last;
    logic              load;
    logic [DATA_W-1:0] slot_data;
    result_t           word;

    // pick the lowest slot still to go
    always_comb
    begin
        remaining = head.mask & ~done_mask_reg;
        sel       = '0;
        idx       = '0;
        found     = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (remaining[i] && !found)
            begin
                sel[i] = 1'b1;
                idx    = SLOT_W'(i);
                found  = 1'b1;
            end
        end
        last = ((remaining & ~sel) == '0);
    end

    // data byte of the chosen slot
    always_comb
    begin
        case (idx)
            SLOT_TRIP_LO: slot_data = head.trip_lo;
            SLOT_TRIP_HI: slot_data = head.trip_hi;
            SLOT_DLOW:    slot_data = {1'b0, head.wr_low};
            SLOT_DMID:    slot_data = {1'b0, head.wr_mid};
            SLOT_DHIGH:   slot_data = {1'b0, head.wr_high};
            default:      slot_data = '0;
        endcase
    end

    // result word; an item with no writes gives one status word
    always_comb
    begin
        word.write_valid   = found;
        word.write_address = found ? slot_address(idx, head.gas) : ADDR_NONE;
        word.write_data    = found ? slot_data : '0;
        word.last_result   = last;
        word.trip_value    = head.trip_value;
        word.dist_low      = head.dist_low;
        word.dist_mid      = head.dist_mid;
        word.dist_high     = head.dist_high;
    end

    assign load  = q_valid && (!out_valid_reg || pop);
    assign q_pop = load && last;

    always_comb
    begin
        done_mask_next = done_mask_reg;
        if (load)
        begin
            done_mask_next = last ? '0 : (done_mask_reg | sel);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_mask_reg <= done_mask_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= word;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    `OPC_ASSERT_IMP(a_done_in_mask, q_valid, (done_mask_reg & ~head.mask) == '0)
    `OPC_ASSERT_IMP(a_done_needs_head, done_mask_reg != '0, q_valid)
    `OPC_ASSERT_NEXT(a_last_clears, q_pop, done_mask_reg == '0)

endmodule

FILE: hw/rtl/odometer_pulse_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometer_pulse_counter_top
// Wheel-pulse odometer: trip and distance counters with nonvolatile
// byte write requests, queue-style word ports on both sides.
//
//   channel   ports                         word
//   input     push, full, item              item_t (opcode and load values)
//   result    empty, pop, result            result_t (write request, counters)
//   config    cfg_we, cfg_index, cfg_data   register write, no read-back
//
// The front updates the counters and classifies a word in the cycle it is
// taken, so a new word can be pushed every cycle while the queue has room.
// The back issues one result word per cycle while results are popped:
// one per write request a word raises (one to five), or one status word.
// Results pass through the descriptor queue, then the output register.
// Reset clears counters, flags and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module odometer_pulse_counter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [opc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [opc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  opc_pkg::item_t                 item,
    output logic                           empty,
    input  logic                           pop,
    output opc_pkg::result_t               result
);
    import opc_pkg::*;

    desc_t front_desc;
    desc_t head_desc;
    logic  accept;
    logic  q_valid;
    logic  q_pop;

    assign accept = push && !full;

    // counters and classification
    opc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .desc      (front_desc)
    );

    // descriptor queue
    opc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_desc),
        .rd_en   (q_pop),
        .rd_data (head_desc),
        .valid   (q_valid),
        .full    (full)
    );

    // result word issue
    opc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head_desc),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
